// ===== hw/rtl/hmtq_pkg.sv =====
// ----------------------------------------------------------------------------
// hmtq_pkg
// Shared types and constants for the min-heap timer queue.
// ----------------------------------------------------------------------------
package hmtq_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int DEF_ID_COUNT = 256;

    localparam int ACTION_W = 3;
    localparam int TID_W    = 8;
    localparam int TOUT_W   = 24;
    localparam int TIME_W   = 32;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_ADJUST = 3'd1,
        ACT_FIRE   = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_CLEAR  = 3'd4
    } hmtq_action_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_NEXT  = 2'd1,
        KIND_ACK   = 2'd2
    } hmtq_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_UNKNOWN = 2'd2
    } hmtq_err_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_REM,
        ST_LAST,
        ST_DN,
        ST_DN1,
        ST_DN2,
        ST_DNC,
        ST_UP,
        ST_UPC,
        ST_PLACE,
        ST_TICK,
        ST_ROOT,
        ST_EMIT
    } hmtq_state_t;

    typedef struct packed {
        hmtq_kind_t         kind;
        logic [TID_W-1:0]   fired_id;
        logic [TIME_W-1:0]  wait_ms;
        logic               queue_empty;
        hmtq_err_t          error;
        logic               last;
    } hmtq_res_t;

endpackage

// ===== hw/rtl/min_heap_timer_queue.sv =====
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Timer queue on a binary min-heap with an id-to-slot map.
// ----------------------------------------------------------------------------
// One beat in at a time: the block is busy from acceptance until its last
// result beat is loaded. An add, adjust or removal walks one heap path.
// Each level of sift-down reads the left child, then the right child where
// there is one, and compares; each level of sift-up reads the parent and
// compares. A tick repeats a removal for every due timer and then sends its
// deadline report. The heap memory's single read port and the one shared
// 32-bit comparator set the pace. The output register lets the sequencer
// run on while a beat waits. A full output register holds the sequencer in
// its emit step.
module min_heap_timer_queue
    import hmtq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ID_COUNT = DEF_ID_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // timer_id[7:0], timeout_ms[31:8], now_ms[63:32]
    input  logic [2:0]  s_tuser,   // action[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // fired_id[7:0], wait_ms[39:8], queue_empty[40],
                                   // error[42:41], zero[47:43]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int ID_W = $clog2(ID_COUNT);

    logic [ID_W-1:0] id_tab [2**TID_W];
    hmtq_res_t       res;

    for (genvar g = 0; g < 2**TID_W; g++) begin : g_idmod
        assign id_tab[g] = ID_W'(g % ID_COUNT);
    end

    hmtq_core #(.CAPACITY(CAPACITY), .ID_COUNT(ID_COUNT)) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_action  (s_tuser),
        .req_id      (id_tab[s_tdata[7:0]]),
        .req_timeout (s_tdata[31:8]),
        .req_now     (s_tdata[63:32]),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {5'd0, res.error, res.queue_empty, res.wait_ms, res.fired_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

// ===== hw/rtl/hmtq_ram.sv =====
// ----------------------------------------------------------------------------
// hmtq_ram
// Single-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module hmtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hmtq_core.sv =====
// ----------------------------------------------------------------------------
// hmtq_core
// Heap sequencer: slot lookup, sift up and down through one shared
// comparator, removal, tick loop and the result register.
// ----------------------------------------------------------------------------
module hmtq_core
    import hmtq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int ID_COUNT = DEF_ID_COUNT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [ACTION_W-1:0]          req_action,
    input  logic [$clog2(ID_COUNT)-1:0]  req_id,
    input  logic [TOUT_W-1:0]            req_timeout,
    input  logic [TIME_W-1:0]            req_now,
    output logic                         res_valid,
    input  logic                         res_ready,
    output hmtq_res_t                    res
);

    localparam int ID_W  = $clog2(ID_COUNT);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int C_W   = IDX_W + 2;
    localparam int HE_W  = ID_W + TIME_W;

    hmtq_state_t state_reg, state_next;

    logic [ACTION_W-1:0] op_reg, op_next;
    logic [ID_W-1:0]     key_reg, key_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [ID_W-1:0]     nid_reg, nid_next;
    logic [TIME_W-1:0]   nexp_reg, nexp_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ID_W-1:0]     cid_reg, cid_next;
    logic [TIME_W-1:0]   cexp_reg, cexp_next;
    logic [IDX_W-1:0]    cidx_reg, cidx_next;
    logic [ID_COUNT-1:0] present_reg, present_next;
    hmtq_res_t           r_reg, r_next;
    hmtq_res_t           out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic             h_we, h_re, s_we, s_re;
    logic [IDX_W-1:0] h_waddr, h_raddr;
    logic [HE_W-1:0]  h_wdata, h_rdata;
    logic [ID_W-1:0]  s_waddr, s_raddr;
    logic [IDX_W-1:0] s_wdata, s_rdata;

    logic [ID_W-1:0]   hd_id;
    logic [TIME_W-1:0] hd_exp;
    logic [TIME_W-1:0] cmp_a, cmp_b, diff;
    logic              earlier, due;
    logic [C_W-1:0]    c_l, c_r, cnt_x;
    logic [IDX_W-1:0]  p_idx;
    logic [CNT_W-1:0]  cnt_dec;
    logic              accept, out_free;

    hmtq_ram #(.WIDTH(HE_W), .DEPTH(CAPACITY)) u_heap (
        .aclk  (aclk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .re    (h_re),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    hmtq_ram #(.WIDTH(IDX_W), .DEPTH(ID_COUNT)) u_slot (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign hd_id    = h_rdata[HE_W-1:TIME_W];
    assign hd_exp   = h_rdata[TIME_W-1:0];
    assign c_l      = {1'b0, idx_reg, 1'b1};
    assign c_r      = c_l + C_W'(1);
    assign cnt_x    = C_W'(cnt_reg);
    assign p_idx    = IDX_W'((idx_reg - IDX_W'(1)) >> 1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign accept   = req_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || res_ready;

    always_comb begin
        case (state_reg)
            ST_DN2: begin
                cmp_a = hd_exp;
                cmp_b = cexp_reg;
            end
            ST_DNC: begin
                cmp_a = nexp_reg;
                cmp_b = cexp_reg;
            end
            ST_UPC: begin
                cmp_a = hd_exp;
                cmp_b = nexp_reg;
            end
            default: begin
                cmp_a = hd_exp;
                cmp_b = now_reg;
            end
        endcase
    end

    assign diff    = cmp_a - cmp_b;
    assign earlier = diff[TIME_W-1];
    assign due     = earlier || (diff == '0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (req_action)
                        ACT_ADD: begin
                            if (present_reg[req_id]) begin
                                state_next = ST_SLOT;
                            end else if (cnt_reg == CNT_W'(CAPACITY)) begin
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_UP;
                            end
                        end
                        ACT_ADJUST, ACT_FIRE: begin
                            state_next = present_reg[req_id] ? ST_SLOT : ST_EMIT;
                        end
                        ACT_TICK: state_next = ST_TICK;
                        default:  state_next = ST_EMIT;
                    endcase
                end
            end
            ST_SLOT: state_next = (op_reg == ACT_FIRE) ? ST_REM : ST_DN;
            ST_REM:  state_next = (CNT_W'(idx_reg) < cnt_dec) ? ST_LAST : ST_EMIT;
            ST_LAST: state_next = ST_DN;
            ST_DN: begin
                if (c_l < cnt_x) begin
                    state_next = ST_DN1;
                end else if (idx_reg != start_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_DN1: state_next = (c_r < cnt_x) ? ST_DN2 : ST_DNC;
            ST_DN2: state_next = ST_DNC;
            ST_DNC: begin
                if (!earlier) begin
                    state_next = ST_DN;
                end else if (idx_reg != start_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_UP;
                end
            end
            ST_UP:    state_next = (idx_reg == '0) ? ST_PLACE : ST_UPC;
            ST_UPC:   state_next = earlier ? ST_PLACE : ST_UP;
            ST_PLACE: state_next = ST_EMIT;
            ST_TICK:  state_next = (cnt_reg == '0) ? ST_EMIT : ST_ROOT;
            ST_ROOT:  state_next = due ? ST_REM : ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = r_reg.last ? ST_IDLE : ST_TICK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next        = op_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        nid_next       = nid_reg;
        nexp_next      = nexp_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        cnt_next       = cnt_reg;
        cid_next       = cid_reg;
        cexp_next      = cexp_reg;
        cidx_next      = cidx_reg;
        present_next   = present_reg;
        r_next         = r_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_ready;
        h_we    = 1'b0;
        h_waddr = idx_reg;
        h_wdata = {nid_reg, nexp_reg};
        h_re    = 1'b0;
        h_raddr = c_l[IDX_W-1:0];
        s_we    = 1'b0;
        s_waddr = nid_reg;
        s_wdata = idx_reg;
        s_re    = 1'b0;
        s_raddr = req_id;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next   = req_action;
                    key_next  = req_id;
                    now_next  = req_now;
                    nid_next  = req_id;
                    nexp_next = req_now + TIME_W'(req_timeout);
                    s_re      = 1'b1;
                    r_next    = '{kind: KIND_ACK, fired_id: '0, wait_ms: '0,
                                  queue_empty: 1'b0, error: ERR_NONE, last: 1'b1};
                    case (req_action)
                        ACT_ADD: begin
                            if (!present_reg[req_id]) begin
                                if (cnt_reg == CNT_W'(CAPACITY)) begin
                                    r_next.error = ERR_FULL;
                                end else begin
                                    idx_next              = cnt_reg[IDX_W-1:0];
                                    start_next            = cnt_reg[IDX_W-1:0];
                                    cnt_next              = cnt_reg + CNT_W'(1);
                                    present_next[req_id]  = 1'b1;
                                end
                            end
                        end
                        ACT_ADJUST: begin
                            if (!present_reg[req_id]) begin
                                r_next.error = ERR_UNKNOWN;
                            end
                        end
                        ACT_FIRE: begin
                            if (present_reg[req_id]) begin
                                r_next.kind     = KIND_FIRED;
                                r_next.fired_id = TID_W'(req_id);
                            end
                        end
                        ACT_CLEAR: begin
                            present_next = '0;
                            cnt_next     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SLOT: begin
                idx_next   = s_rdata;
                start_next = s_rdata;
            end
            ST_REM: begin
                present_next[key_reg] = 1'b0;
                cnt_next              = cnt_dec;
                start_next            = idx_reg;
                h_re                  = 1'b1;
                h_raddr               = cnt_dec[IDX_W-1:0];
            end
            ST_LAST: begin
                nid_next  = hd_id;
                nexp_next = hd_exp;
            end
            ST_DN: begin
                h_re    = c_l < cnt_x;
                h_raddr = c_l[IDX_W-1:0];
            end
            ST_DN1: begin
                cid_next  = hd_id;
                cexp_next = hd_exp;
                cidx_next = c_l[IDX_W-1:0];
                h_re      = c_r < cnt_x;
                h_raddr   = c_r[IDX_W-1:0];
            end
            ST_DN2: begin
                if (earlier) begin
                    cid_next  = hd_id;
                    cexp_next = hd_exp;
                    cidx_next = c_r[IDX_W-1:0];
                end
            end
            ST_DNC: begin
                if (!earlier) begin
                    h_we     = 1'b1;
                    h_wdata  = {cid_reg, cexp_reg};
                    s_we     = 1'b1;
                    s_waddr  = cid_reg;
                    idx_next = cidx_reg;
                end
            end
            ST_UP: begin
                h_re    = idx_reg != '0;
                h_raddr = p_idx;
            end
            ST_UPC: begin
                if (!earlier) begin
                    h_we     = 1'b1;
                    h_wdata  = h_rdata;
                    s_we     = 1'b1;
                    s_waddr  = hd_id;
                    idx_next = p_idx;
                end
            end
            ST_PLACE: begin
                h_we = 1'b1;
                s_we = 1'b1;
            end
            ST_TICK: begin
                h_re    = cnt_reg != '0;
                h_raddr = '0;
                r_next  = '{kind: KIND_NEXT, fired_id: '0, wait_ms: '1,
                            queue_empty: 1'b0, error: ERR_NONE, last: 1'b1};
            end
            ST_ROOT: begin
                if (due) begin
                    key_next        = hd_id;
                    idx_next        = '0;
                    r_next.kind     = KIND_FIRED;
                    r_next.fired_id = TID_W'(hd_id);
                    r_next.wait_ms  = '0;
                    r_next.last     = 1'b0;
                end else begin
                    r_next.wait_ms = diff;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_next             = r_reg;
                    out_next.queue_empty = cnt_reg == '0;
                    out_valid_next       = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            present_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            present_reg   <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        now_reg   <= now_next;
        nid_reg   <= nid_next;
        nexp_reg  <= nexp_next;
        idx_reg   <= idx_next;
        start_reg <= start_next;
        cid_reg   <= cid_next;
        cexp_reg  <= cexp_next;
        cidx_reg  <= cidx_next;
        r_reg     <= r_next;
        out_reg   <= out_next;
    end

    assign req_ready = state_reg == ST_IDLE;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule
